### design/fifo_page_replacement_defines.svh
`ifndef FIFO_PAGE_REPLACEMENT_DEFINES_SVH
`define FIFO_PAGE_REPLACEMENT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/fpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpr_pkg;

  localparam int FPR_MAX_FRAMES = 16;
  localparam int FPR_PAGE_BITS  = 10;
  localparam int FPR_COUNT_BITS = 32;

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] FPR_CFG_RESET = 5'd16;

  typedef enum logic [1:0] {
    OUT_HIT        = 2'd0,
    OUT_COMPULSORY = 2'd1,
    OUT_CAPACITY   = 2'd2
  } fpr_outcome_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } fpr_state_t;

  typedef struct packed {
    logic hit;
    logic victim_valid;
  } fpr_lookup_t;

endpackage

`default_nettype wire

### design/fpr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fpr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/fpr_frame_table.sv
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_page_replacement_defines.svh"

module fpr_frame_table import fpr_pkg::*; #(
  parameter int MAX_FRAMES = FPR_MAX_FRAMES,
  parameter int PAGE_BITS  = FPR_PAGE_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_W-1:0]     cfg_frames,
  input  wire logic                 lookup_en,
  input  wire logic [PAGE_BITS-1:0] page,
  output fpr_lookup_t               lookup,
  output logic      [PAGE_BITS-1:0] victim_page
);

  localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FILL_W = $clog2(MAX_FRAMES + 1);
  localparam int LIM_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;

  logic [CFG_W-1:0]     frames_cfg_r;
  logic [PAGE_BITS-1:0] frame_page_r [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_r, valid_nxt;
  logic [FILL_W-1:0]    filled_r, filled_nxt;
  logic [IDX_W-1:0]     oldest_r, oldest_nxt;

  logic [LIM_W-1:0]     cfg_ext, lim_ext;
  logic [FILL_W-1:0]    lim;
  logic [FILL_W-1:0]    old_inc;
  logic [MAX_FRAMES-1:0] match;
  logic                 hit, miss, has_free, wr_en;
  logic [IDX_W-1:0]     wr_idx;

  always_comb begin
    cfg_ext = LIM_W'(frames_cfg_r);
    if (cfg_ext == '0) begin
      lim_ext = LIM_W'(1);
    end else if (cfg_ext > LIM_W'(MAX_FRAMES)) begin
      lim_ext = LIM_W'(MAX_FRAMES);
    end else begin
      lim_ext = cfg_ext;
    end
  end

  assign lim = lim_ext[FILL_W-1:0];

  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      match[i] = valid_r[i] && (frame_page_r[i] == page);
    end
  end

  assign hit      = |match;
  assign miss     = lookup_en && !hit;
  assign has_free = filled_r < lim;
  assign old_inc  = FILL_W'(oldest_r) + FILL_W'(1);
  assign wr_en    = miss;
  assign wr_idx   = has_free ? filled_r[IDX_W-1:0] : oldest_r;

  always_comb begin
    valid_nxt  = valid_r;
    filled_nxt = filled_r;
    oldest_nxt = oldest_r;
    if (cfg_we) begin
      valid_nxt  = '0;
      filled_nxt = '0;
      oldest_nxt = '0;
    end else if (miss) begin
      valid_nxt[wr_idx] = 1'b1;
      if (has_free) begin
        filled_nxt = filled_r + FILL_W'(1);
      end else begin
        oldest_nxt = (old_inc >= filled_r) ? '0 : old_inc[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_cfg_r <= FPR_CFG_RESET;
      valid_r      <= '0;
      filled_r     <= '0;
      oldest_r     <= '0;
    end else begin
      if (cfg_we) begin
        frames_cfg_r <= cfg_frames;
      end
      valid_r  <= valid_nxt;
      filled_r <= filled_nxt;
      oldest_r <= oldest_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_page_r[wr_idx] <= page;
    end
  end

  assign lookup.hit          = hit;
  assign lookup.victim_valid = lookup_en && !hit && !has_free;
  assign victim_page         = lookup.victim_valid ? frame_page_r[oldest_r] : '0;

  `FPR_ASSERT_NOW(a_fill_bound, 1'b1, filled_r <= lim, "frames filled beyond limit")
  `FPR_ASSERT_NOW(a_oldest_in_range, 1'b1, (FILL_W'(oldest_r) < filled_r) || (oldest_r == '0), "oldest frame outside filled range")

endmodule

`default_nettype wire

### design/fpr_seen_map.sv
`timescale 1ns / 1ps
`default_nettype none

module fpr_seen_map import fpr_pkg::*; #(
  parameter int PAGE_BITS = FPR_PAGE_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [PAGE_BITS-1:0] rd_page,
  input  wire logic [PAGE_BITS-1:0] chk_page,
  input  wire logic                 wr_en,
  input  wire logic [PAGE_BITS-1:0] wr_page,
  output logic                      seen,
  output logic                      clearing
);

  fpr_state_t           state_r, state_nxt;
  logic [PAGE_BITS-1:0] clr_addr_r, clr_addr_nxt;
  logic                 fwd_valid_r;
  logic [PAGE_BITS-1:0] fwd_page_r;
  logic                 ram_we, ram_wdata, ram_rdata;
  logic [PAGE_BITS-1:0] ram_waddr;

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + PAGE_BITS'(1);
        if (clr_addr_r == '1) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      fwd_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    fwd_page_r <= wr_page;
  end

  assign clearing  = (state_r != ST_RUN);
  assign ram_we    = clearing || wr_en;
  assign ram_waddr = clearing ? clr_addr_r : wr_page;
  assign ram_wdata = !clearing;

  fpr_ram #(
    .WIDTH (1),
    .DEPTH (1 << PAGE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_page),
    .rdata (ram_rdata)
  );

  // write from the previous transaction lands on the same edge as this read
  assign seen = ram_rdata || (fwd_valid_r && (fwd_page_r == chk_page));

endmodule

`default_nettype wire

### design/fifo_page_replacement.sv
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_page_replacement_defines.svh"
// Results: a transaction accepted at a clock edge is registered into the s1 stage, and its
//   result is then registered onto the out_ ports, marked by out_strobe.
// Throughput: one transaction per cycle while busy is low; the frame table and counters
//   sit in flip-flops and the seen-page RAM read is pipelined one stage ahead with write forwarding.
// Reset: synchronous, active-low; afterwards busy stays high while all 2**PAGE_BITS entries
//   (1024 by default) of the seen-page RAM are cleared, one entry per cycle.

module fifo_page_replacement import fpr_pkg::*; #(
  parameter int MAX_FRAMES = FPR_MAX_FRAMES,
  parameter int PAGE_BITS  = FPR_PAGE_BITS,
  parameter int COUNT_BITS = FPR_COUNT_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [PAGE_BITS-1:0]  in_page_number,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_W-1:0]      cfg_frames_in_use,
  output logic                       out_strobe,
  output logic      [1:0]            out_outcome,
  output logic                       out_victim_valid,
  output logic      [PAGE_BITS-1:0]  out_victim_page,
  output logic      [COUNT_BITS-1:0] out_compulsory_total,
  output logic      [COUNT_BITS-1:0] out_capacity_total
);

  logic                  accept;
  logic                  s1_valid_r;
  logic [PAGE_BITS-1:0]  s1_page_r;
  fpr_lookup_t           lookup;
  logic [PAGE_BITS-1:0]  victim_page;
  logic                  seen, clearing, miss;
  fpr_outcome_t          outcome_nxt;

  logic                  out_valid_r;
  fpr_outcome_t          out_outcome_r;
  logic                  out_victim_valid_r;
  logic [PAGE_BITS-1:0]  out_victim_page_r;
  logic [COUNT_BITS-1:0] compulsory_count_r, compulsory_count_nxt;
  logic [COUNT_BITS-1:0] capacity_count_r, capacity_count_nxt;

  assign busy   = clearing;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_page_r <= in_page_number;
    end
  end

  fpr_frame_table #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_frames  (cfg_frames_in_use),
    .lookup_en   (s1_valid_r),
    .page        (s1_page_r),
    .lookup      (lookup),
    .victim_page (victim_page)
  );

  assign miss = s1_valid_r && !lookup.hit;

  fpr_seen_map #(
    .PAGE_BITS (PAGE_BITS)
  ) u_seen (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_page  (in_page_number),
    .chk_page (s1_page_r),
    .wr_en    (miss),
    .wr_page  (s1_page_r),
    .seen     (seen),
    .clearing (clearing)
  );

  always_comb begin
    outcome_nxt          = OUT_HIT;
    compulsory_count_nxt = compulsory_count_r;
    capacity_count_nxt   = capacity_count_r;
    if (miss) begin
      if (!seen) begin
        outcome_nxt = OUT_COMPULSORY;
        if (compulsory_count_r != '1) begin
          compulsory_count_nxt = compulsory_count_r + COUNT_BITS'(1);
        end
      end else begin
        outcome_nxt = OUT_CAPACITY;
        if (capacity_count_r != '1) begin
          capacity_count_nxt = capacity_count_r + COUNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r        <= 1'b0;
      compulsory_count_r <= '0;
      capacity_count_r   <= '0;
    end else begin
      out_valid_r        <= s1_valid_r;
      compulsory_count_r <= compulsory_count_nxt;
      capacity_count_r   <= capacity_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_outcome_r      <= outcome_nxt;
      out_victim_valid_r <= lookup.victim_valid;
      out_victim_page_r  <= victim_page;
    end
  end

  assign out_strobe           = out_valid_r;
  assign out_outcome          = out_outcome_r;
  assign out_victim_valid     = out_victim_valid_r;
  assign out_victim_page      = out_victim_page_r;
  assign out_compulsory_total = compulsory_count_r;
  assign out_capacity_total   = capacity_count_r;

  `FPR_ASSERT_NEXT(a_result_follows, s1_valid_r, out_valid_r, "lookup without result strobe")
  `FPR_ASSERT_NOW(a_victim_on_miss, out_valid_r && out_victim_valid_r, out_outcome_r != OUT_HIT, "victim reported on a hit")
  `FPR_ASSERT_NEXT(a_compulsory_rising, 1'b1, compulsory_count_r >= $past(compulsory_count_r), "compulsory count went down")
  `FPR_ASSERT_NEXT(a_capacity_rising, 1'b1, capacity_count_r >= $past(capacity_count_r), "capacity count went down")

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import fpr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef struct {
    fpr_outcome_t                outcome;
    logic                        victim_valid;
    logic [FPR_PAGE_BITS-1:0]    victim_page;
    logic [FPR_COUNT_BITS-1:0]   compulsory_total;
    logic [FPR_COUNT_BITS-1:0]   capacity_total;
  } page_result_t;

  class page_table_scoreboard;
    logic [FPR_PAGE_BITS-1:0]  frame_page [FPR_MAX_FRAMES];
    bit                        frame_held [FPR_MAX_FRAMES];
    int unsigned               filled;
    int unsigned               oldest;
    bit                        page_seen [1 << FPR_PAGE_BITS];
    logic [FPR_COUNT_BITS-1:0] compulsory_misses;
    logic [FPR_COUNT_BITS-1:0] capacity_misses;
    logic [CFG_W-1:0]          frames_setting;
    page_result_t              pending_results [$];
    int unsigned               errors;

    function new();
      frames_setting = FPR_CFG_RESET;
      flush_frames();
      foreach (page_seen[i]) page_seen[i] = 1'b0;
      compulsory_misses = '0;
      capacity_misses = '0;
      errors = 0;
    endfunction

    function void flush_frames();
      foreach (frame_page[i]) begin
        frame_page[i] = '0;
        frame_held[i] = 1'b0;
      end
      filled = 0;
      oldest = 0;
    endfunction

    function void set_frame_limit(logic [CFG_W-1:0] value);
      frames_setting = value;
      flush_frames();
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    // expected result of one page reference, applied to the local table copy
    function void note_reference(logic [FPR_PAGE_BITS-1:0] page);
      page_result_t r;
      int unsigned  lim;
      int unsigned  f;
      bit           hit;
      lim = (frames_setting == 0) ? 1 :
            (frames_setting > FPR_MAX_FRAMES) ? FPR_MAX_FRAMES : frames_setting;
      hit = 1'b0;
      for (int i = 0; i < FPR_MAX_FRAMES; i++)
        if (frame_held[i] && frame_page[i] == page) hit = 1'b1;
      r.outcome = OUT_HIT;
      r.victim_valid = 1'b0;
      r.victim_page = '0;
      if (!hit) begin
        if (filled < lim) begin
          frame_page[filled] = page;
          frame_held[filled] = 1'b1;
          filled++;
        end else begin
          f = oldest % FPR_MAX_FRAMES;
          r.victim_valid = 1'b1;
          r.victim_page = frame_page[f];
          frame_page[f] = page;
          frame_held[f] = 1'b1;
          oldest = (f + 1 >= filled) ? 0 : f + 1;
        end
        if (!page_seen[page]) begin
          page_seen[page] = 1'b1;
          if (compulsory_misses != '1) compulsory_misses++;
          r.outcome = OUT_COMPULSORY;
        end else begin
          if (capacity_misses != '1) capacity_misses++;
          r.outcome = OUT_CAPACITY;
        end
      end
      r.compulsory_total = compulsory_misses;
      r.capacity_total = capacity_misses;
      pending_results.push_back(r);
    endfunction

    function int unsigned pending_count();
      return pending_results.size();
    endfunction

    task check_result(logic [1:0] outcome, logic victim_valid,
                      logic [FPR_PAGE_BITS-1:0] victim_page,
                      logic [FPR_COUNT_BITS-1:0] compulsory_total,
                      logic [FPR_COUNT_BITS-1:0] capacity_total);
      page_result_t e;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction waiting");
        return;
      end
      e = pending_results.pop_front();
      if (outcome !== e.outcome)
        report_mismatch($sformatf("outcome %0d, expected %0d", outcome, e.outcome));
      if (victim_valid !== e.victim_valid)
        report_mismatch($sformatf("victim_valid %b, expected %b",
                                  victim_valid, e.victim_valid));
      if (victim_page !== e.victim_page)
        report_mismatch($sformatf("victim_page %0d, expected %0d",
                                  victim_page, e.victim_page));
      if (compulsory_total !== e.compulsory_total)
        report_mismatch($sformatf("compulsory_total %0d, expected %0d",
                                  compulsory_total, e.compulsory_total));
      if (capacity_total !== e.capacity_total)
        report_mismatch($sformatf("capacity_total %0d, expected %0d",
                                  capacity_total, e.capacity_total));
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [FPR_PAGE_BITS-1:0]  in_page_number;
  logic                      cfg_we;
  logic [CFG_W-1:0]          cfg_frames_in_use;
  logic                      out_strobe;
  logic [1:0]                out_outcome;
  logic                      out_victim_valid;
  logic [FPR_PAGE_BITS-1:0]  out_victim_page;
  logic [FPR_COUNT_BITS-1:0] out_compulsory_total;
  logic [FPR_COUNT_BITS-1:0] out_capacity_total;

  page_table_scoreboard sb;
  int unsigned          cycles = 0;

  fifo_page_replacement dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_page_number       (in_page_number),
    .cfg_we               (cfg_we),
    .cfg_frames_in_use    (cfg_frames_in_use),
    .out_strobe           (out_strobe),
    .out_outcome          (out_outcome),
    .out_victim_valid     (out_victim_valid),
    .out_victim_page      (out_victim_page),
    .out_compulsory_total (out_compulsory_total),
    .out_capacity_total   (out_capacity_total)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1)
      sb.check_result(out_outcome, out_victim_valid, out_victim_page,
                      out_compulsory_total, out_capacity_total);
  end

  function automatic int unsigned draw_gap(bit burst);
    if (burst || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic send_reference(input logic [FPR_PAGE_BITS-1:0] page, input int unsigned gap);
    start <= 1'b1;
    in_page_number <= page;
    do @(posedge clk); while (busy);
    sb.note_reference(page);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_frames_in_use <= value;
    @(posedge clk);
    sb.set_frame_limit(value);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0]         setting;
    logic [FPR_PAGE_BITS-1:0] page;
    logic [CFG_W-1:0]         plan [9];
    int unsigned              lim;
    int unsigned              span;
    int unsigned              base;
    bit                       burst;

    sb = new();
    plan = '{5'd4, 5'd31, 5'd1, 5'd0, 5'd16, 5'd17, 5'd2, 5'd8, 5'd15};
    rst_n <= 1'b0;
    start <= 1'b0;
    in_page_number <= '0;
    cfg_we <= 1'b0;
    cfg_frames_in_use <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // extreme pages, hits, and the frame limits at both ends
    send_reference(10'd0, draw_gap(0));
    send_reference(10'd1023, draw_gap(0));
    send_reference(10'd0, draw_gap(0));
    send_reference(10'd1023, draw_gap(0));
    send_reference(10'h155, draw_gap(0));
    send_reference(10'h2AA, draw_gap(0));
    write_frames(5'd1);
    send_reference(10'd0, draw_gap(0));
    send_reference(10'd0, draw_gap(0));
    send_reference(10'd1023, draw_gap(0));
    send_reference(10'd7, draw_gap(0));
    send_reference(10'd0, draw_gap(0));
    write_frames(5'd0);
    send_reference(10'd7, draw_gap(0));
    send_reference(10'd7, draw_gap(0));
    send_reference(10'd8, draw_gap(0));
    send_reference(10'd7, draw_gap(0));
    write_frames(5'd2);
    send_reference(10'd1, draw_gap(0));
    send_reference(10'd2, draw_gap(0));
    send_reference(10'd1, draw_gap(0));
    send_reference(10'd3, draw_gap(0));
    send_reference(10'd2, draw_gap(0));
    write_frames(5'd31);
    send_reference(10'd1, draw_gap(0));
    send_reference(10'd2, draw_gap(0));

    // working-set phases, mostly reuse so hits and capacity misses dominate
    for (int p = 0; p < 11; p++) begin
      setting = (p < 9) ? plan[p] : CFG_W'($urandom_range(0, 31));
      write_frames(setting);
      lim = (setting == 0) ? 1 : (setting > FPR_MAX_FRAMES) ? FPR_MAX_FRAMES : setting;
      span = lim + $urandom_range(0, 8);
      base = $urandom_range(0, 1023);
      burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 150; n++) begin
        if (p == 2 && n == 60) drain_results();
        if ($urandom_range(0, 39) == 0) base = $urandom_range(0, 1023);
        if ($urandom_range(0, 99) < 80)
          page = FPR_PAGE_BITS'(base + $urandom_range(0, span - 1));
        else
          page = FPR_PAGE_BITS'($urandom_range(0, 1023));
        send_reference(page, draw_gap(burst));
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.pending_count() != 0) sb.report_mismatch("expected results left over");
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
